// ===== hdl/idle_gap_frame_assembler_assert.svh =====
// Assertion macros shared by the frame assembler RTL
`ifndef IDLE_GAP_FRAME_ASSEMBLER_ASSERT_SVH
`define IDLE_GAP_FRAME_ASSEMBLER_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define IGFA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define IGFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/igfa_pkg.sv =====
// Shared widths, the limit reset value and event codes of the frame assembler
package igfa_pkg;

   localparam int MODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int LIMIT_W = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd5;

   // event codes carried in the mode field
   typedef enum logic [MODE_W-1:0] {
      MODE_GOOD = 2'd0,
      MODE_ERR  = 2'd1,
      MODE_TICK = 2'd2,
      MODE_READ = 2'd3
   } mode_type;

endpackage

// ===== hdl/igfa_channels.sv =====
// Valid/ready channel interfaces: request, response and register write
interface igfa_req_if;
   import igfa_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, mode, rx_byte, input ready);
   modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface igfa_rsp_if;
   import igfa_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_valid;
   logic              last;
   logic [LEN_W-1:0]  frame_length;
   logic              frame_ready;
   modport source (output valid, out_byte, byte_valid, last, frame_length, frame_ready,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, last, frame_length, frame_ready,
                   output ready);
endinterface

interface igfa_csr_if;
   import igfa_pkg::*;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] silence_limit;
   modport source (output valid, silence_limit, input ready);
   modport sink   (input valid, silence_limit, output ready);
endinterface

// ===== hdl/idle_gap_frame_assembler.sv =====
// Idle-gap frame assembler: byte buffer in RAM, silence timeout, frame read out.
// Byte, error and tick events: one word per cycle while the output is free, status
// word in the next cycle. Read out: bytes pass RAM read and output registers, one per
// cycle if not stalled (one RAM read port); no new word is taken until the last byte leaves.
// Synchronous active-high reset clears counters, flags, limit (to 5) and output valid;
// buffer contents are not cleared and are only read once written.
`include "idle_gap_frame_assembler_assert.svh"

module idle_gap_frame_assembler #(
   parameter int BUF_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   igfa_req_if.sink   req_ch,
   igfa_rsp_if.source rsp_ch,
   igfa_csr_if.sink   csr_ch
);
   import igfa_pkg::*;

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [LIMIT_W-1:0] silence_ff, silence_in;
   logic               ready_ff, ready_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [CW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      out_cnt_ff, out_cnt_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // read-out context and output payload
   logic [CW-1:0]      len_ff, len_in;
   logic               was_ready_ff, was_ready_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_bvalid_ff, rsp_bvalid_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic               rsp_rdy_ff, rsp_rdy_in;

   logic               out_free;
   logic               req_take;
   logic               load;
   logic               issue;
   logic               last_beat;
   logic [LIMIT_W-1:0] sil_inc;
   logic               wr_en;
   logic [BYTE_W-1:0]  rd_data;

   // frame buffer
   igfa_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_ch.rx_byte),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // handshake and read pipeline control
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign load         = pend_ff && out_free;
   assign issue        = (state_ff == ST_READ) && (rd_ptr_ff < len_ff) && (!pend_ff || load);
   assign last_beat    = (out_cnt_ff + CW'(1)) == len_ff;
   assign sil_inc      = silence_ff + LIMIT_W'(1);
   assign wr_en        = req_take && (req_ch.mode == MODE_GOOD) && (fill_ff < DEPTH_C);

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      silence_in    = silence_ff;
      ready_in      = ready_ff;
      limit_in      = limit_ff;
      rd_ptr_in     = rd_ptr_ff;
      out_cnt_in    = out_cnt_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      len_in        = len_ff;
      was_ready_in  = was_ready_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_rdy_in    = rsp_rdy_ff;

      if (csr_ch.valid) begin
         limit_in = csr_ch.silence_limit;
      end

      // event handling
      if (req_take) begin
         case (req_ch.mode)
            MODE_GOOD: begin
               if (fill_ff < DEPTH_C) begin
                  fill_in = fill_ff + CW'(1);
               end
               silence_in = '0;
            end
            MODE_ERR: begin
            end
            MODE_TICK: begin
               if (fill_ff != '0) begin
                  if (sil_inc >= limit_ff) begin
                     ready_in   = 1'b1;
                     silence_in = '0;
                  end else begin
                     silence_in = sil_inc;
                  end
               end
            end
            MODE_READ: begin
               len_in       = fill_ff;
               was_ready_in = ready_ff;
               fill_in      = '0;
               ready_in     = 1'b0;
               silence_in   = '0;
               if (fill_ff == '0) begin
                  // empty frame: single status word
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = '0;
                  rsp_bvalid_in = 1'b0;
                  rsp_last_in   = 1'b1;
                  rsp_len_in    = '0;
                  rsp_rdy_in    = ready_ff;
               end else begin
                  state_in   = ST_READ;
                  rd_ptr_in  = '0;
                  out_cnt_in = '0;
               end
            end
            default: begin
            end
         endcase

         // status word for byte, error and tick events
         if (req_ch.mode != MODE_READ) begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = '0;
            rsp_bvalid_in = 1'b0;
            rsp_last_in   = 1'b1;
            rsp_len_in    = LEN_W'(fill_in);
            rsp_rdy_in    = ready_in;
         end
      end

      // read out: fetch next entry, move fetched entry to output
      if (issue) begin
         rd_ptr_in = rd_ptr_ff + CW'(1);
         pend_in   = 1'b1;
      end else if (load) begin
         pend_in = 1'b0;
      end

      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = rd_data;
         rsp_bvalid_in = 1'b1;
         rsp_last_in   = last_beat;
         rsp_len_in    = LEN_W'(len_ff);
         rsp_rdy_in    = was_ready_ff;
         out_cnt_in    = out_cnt_ff + CW'(1);
         if (last_beat) begin
            state_in = ST_IDLE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         silence_ff   <= '0;
         ready_ff     <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rd_ptr_ff    <= '0;
         out_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         silence_ff   <= silence_in;
         ready_ff     <= ready_in;
         limit_ff     <= limit_in;
         rd_ptr_ff    <= rd_ptr_in;
         out_cnt_ff   <= out_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      was_ready_ff  <= was_ready_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_rdy_ff    <= rsp_rdy_in;
   end

   // response port
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = rsp_byte_ff;
   assign rsp_ch.byte_valid   = rsp_bvalid_ff;
   assign rsp_ch.last         = rsp_last_ff;
   assign rsp_ch.frame_length = rsp_len_ff;
   assign rsp_ch.frame_ready  = rsp_rdy_ff;

   // checks
   `IGFA_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= DEPTH_C, "fill count above buffer depth")
   `IGFA_ASSERT_IMPL(a_ready_nonempty, ready_ff, fill_ff != '0, "frame ready with empty buffer")
   `IGFA_ASSERT_IMPL(a_pend_in_read, pend_ff, state_ff == ST_READ, "fetched byte outside read out")
   `IGFA_ASSERT_IMPL(a_no_take_in_read, state_ff == ST_READ, !req_ch.ready, "request taken during read")
   `IGFA_ASSERT_NEXT(a_end_of_read, load && last_beat, state_ff == ST_IDLE && !pend_ff, "read out did not finish")

endmodule

// ===== hdl/igfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module igfa_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
